// ===== hdl/mbq_pkg.sv =====
// ----------------------------------------------------------------------------
// mbq_pkg
// Shared types, widths and register indexes of the multichannel biquad filter.
// ----------------------------------------------------------------------------
package mbq_pkg;

  localparam int MAX_CHANNELS = 8;
  localparam int SAMPLE_W     = 24;
  localparam int COEF_W       = 32;
  localparam int COEF_FRAC    = COEF_W - 2;
  localparam int CH_W         = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int CNT_W        = 4;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = COEF_W;

  // Product of one sample and one coefficient, and the sum of five of them
  localparam int PROD_W = SAMPLE_W + COEF_W;
  localparam int ACC_W  = PROD_W + 3;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_COEF_B0       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_B1       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_B2       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_A1       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_A2       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FILTER_ENABLE = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 3'd6;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [COEF_W-1:0]   coef_t;
  typedef logic [CH_W-1:0]            chan_t;
  typedef logic [CNT_W-1:0]           count_t;

  // Live configuration seen by the datapath
  typedef struct packed {
    coef_t  b0;
    coef_t  b1;
    coef_t  b2;
    coef_t  a1;
    coef_t  a2;
    logic   enable;
    count_t count;
  } cfg_t;

  // Per-channel history: two past inputs and two past outputs
  typedef struct packed {
    sample_t x1;
    sample_t x2;
    sample_t y1;
    sample_t y2;
  } hist_t;

endpackage

// ===== hdl/mbq_stream_if.sv =====
// ----------------------------------------------------------------------------
// mbq_in_if / mbq_out_if
// Valid/ready sample channels into and out of the biquad filter.
// ----------------------------------------------------------------------------
interface mbq_in_if;
  import mbq_pkg::*;

  logic    valid;
  logic    ready;
  sample_t sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink   (input valid, input sample_in, output ready);
endinterface

interface mbq_out_if;
  import mbq_pkg::*;

  logic    valid;
  logic    ready;
  sample_t sample_out;
  chan_t   channel_index;

  modport source (output valid, output sample_out, output channel_index, input ready);
  modport sink   (input valid, input sample_out, input channel_index, output ready);
endinterface

// ===== hdl/multichannel_biquad_filter.sv =====
// ----------------------------------------------------------------------------
// multichannel_biquad_filter
// Interleaved-channel direct-form-I biquad with per-channel history.
// ----------------------------------------------------------------------------
//  channel   dir   payload                       beat
//  in_ch     in    sample_in                     one sample, next channel
//  out_ch    out   sample_out, channel_index     one filtered sample
//  cfg       in    cfg_we, cfg_index, cfg_data   one register write
//
// One beat per cycle sustained while out_ch is not stalled; an accepted sample
// passes the input register, then is multiply-accumulated into the result
// register. History is written as each result is registered while the filter
// is enabled, so back-to-back samples of one channel see it. Reset restores the
// registers and clears history, channel counter and both valid flags. A stalled
// output drops in_ch.ready only once the input register is also full.
// ----------------------------------------------------------------------------
module multichannel_biquad_filter (
  input  logic                            clk,
  input  logic                            rst,
  mbq_in_if.sink                          in_ch,
  mbq_out_if.source                       out_ch,
  input  logic                            cfg_we,
  input  logic [mbq_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [mbq_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import mbq_pkg::*;

  cfg_t    cfg;
  hist_t   rd_hist;
  sample_t mac_y;
  sample_t y_sel;

  chan_t   cur_ch;
  chan_t   cur_ch_next;
  count_t  eff_count;

  logic    s1_valid;
  sample_t s1_x;
  chan_t   s1_ch;

  logic    o_valid;
  sample_t o_sample;
  chan_t   o_ch;

  logic    out_free;
  logic    in_take;
  logic    s1_move;

  mbq_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  mbq_hist u_hist (
    .clk     (clk),
    .rst     (rst),
    .rd_ch   (s1_ch),
    .rd_hist (rd_hist),
    .wr_en   (s1_move && cfg.enable),
    .wr_ch   (s1_ch),
    .wr_x    (s1_x),
    .wr_y    (mac_y)
  );

  mbq_mac u_mac (
    .x    (s1_x),
    .hist (rd_hist),
    .cfg  (cfg),
    .y    (mac_y)
  );

  // Handshake
  assign out_free    = !o_valid || out_ch.ready;
  assign s1_move     = s1_valid && out_free;
  assign in_ch.ready = !s1_valid || out_free;
  assign in_take     = in_ch.valid && in_ch.ready;

  // Channel count clamped to 1..MAX_CHANNELS; counter wraps at it
  always_comb begin
    if (cfg.count == '0) begin
      eff_count = count_t'(1);
    end else if (cfg.count > count_t'(MAX_CHANNELS)) begin
      eff_count = count_t'(MAX_CHANNELS);
    end else begin
      eff_count = cfg.count;
    end
    if ((CNT_W+1)'(cur_ch) + (CNT_W+1)'(1) >= (CNT_W+1)'(eff_count)) begin
      cur_ch_next = '0;
    end else begin
      cur_ch_next = cur_ch + chan_t'(1);
    end
  end

  assign y_sel = cfg.enable ? mac_y : s1_x;

  // Channel counter, advanced per accepted beat
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_ch <= '0;
    end else if (in_take) begin
      cur_ch <= cur_ch_next;
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_x  <= in_ch.sample_in;
      s1_ch <= cur_ch;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (out_free) begin
      o_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      o_sample <= y_sel;
      o_ch     <= s1_ch;
    end
  end

  assign out_ch.valid         = o_valid;
  assign out_ch.sample_out    = o_sample;
  assign out_ch.channel_index = o_ch;

endmodule

// ===== hdl/mbq_cfg.sv =====
// ----------------------------------------------------------------------------
// mbq_cfg
// Configuration register file: coefficients, enable and channel count.
// ----------------------------------------------------------------------------
module mbq_cfg (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [mbq_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [mbq_pkg::CFG_DATA_W-1:0]   cfg_data,
  output mbq_pkg::cfg_t                    cfg
);
  import mbq_pkg::*;

  cfg_t regs;

  // Register writes; unused index is dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      regs.b0     <= coef_t'(64'sd1 <<< COEF_FRAC);
      regs.b1     <= '0;
      regs.b2     <= '0;
      regs.a1     <= '0;
      regs.a2     <= '0;
      regs.enable <= 1'b0;
      regs.count  <= count_t'(2);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_COEF_B0:       regs.b0     <= coef_t'(cfg_data);
        REG_COEF_B1:       regs.b1     <= coef_t'(cfg_data);
        REG_COEF_B2:       regs.b2     <= coef_t'(cfg_data);
        REG_COEF_A1:       regs.a1     <= coef_t'(cfg_data);
        REG_COEF_A2:       regs.a2     <= coef_t'(cfg_data);
        REG_FILTER_ENABLE: regs.enable <= cfg_data[0];
        REG_CHANNEL_COUNT: regs.count  <= cfg_data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg = regs;

endmodule

// ===== hdl/mbq_hist.sv =====
// ----------------------------------------------------------------------------
// mbq_hist
// Per-channel filter history, one read and one write channel per cycle.
// ----------------------------------------------------------------------------
module mbq_hist (
  input  logic             clk,
  input  logic             rst,
  input  mbq_pkg::chan_t   rd_ch,
  output mbq_pkg::hist_t   rd_hist,
  input  logic             wr_en,
  input  mbq_pkg::chan_t   wr_ch,
  input  mbq_pkg::sample_t wr_x,
  input  mbq_pkg::sample_t wr_y
);
  import mbq_pkg::*;

  hist_t hist [MAX_CHANNELS];

  assign rd_hist = hist[rd_ch];

  // Shift the new input and output into the channel's history
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_CHANNELS; i++) begin
        hist[i] <= '0;
      end
    end else if (wr_en) begin
      hist[wr_ch].x2 <= hist[wr_ch].x1;
      hist[wr_ch].x1 <= wr_x;
      hist[wr_ch].y2 <= hist[wr_ch].y1;
      hist[wr_ch].y1 <= wr_y;
    end
  end

endmodule

// ===== hdl/mbq_mac.sv =====
// ----------------------------------------------------------------------------
// mbq_mac
// Direct-form-I biquad arithmetic: five products, sum, round, saturate.
// ----------------------------------------------------------------------------
module mbq_mac (
  input  mbq_pkg::sample_t x,
  input  mbq_pkg::hist_t   hist,
  input  mbq_pkg::cfg_t    cfg,
  output mbq_pkg::sample_t y
);
  import mbq_pkg::*;

  localparam int SH_W = ACC_W - COEF_FRAC;
  localparam logic signed [ACC_W-1:0] RND = ACC_W'(1) <<< (COEF_FRAC - 1);

  logic signed [PROD_W-1:0] p_b0, p_b1, p_b2, p_a1, p_a2;
  logic signed [ACC_W-1:0]  acc;
  logic signed [SH_W-1:0]   sh;
  logic                     ovf;

  // Q1.23 x Q2.30 products
  assign p_b0 = PROD_W'(x)       * PROD_W'(cfg.b0);
  assign p_b1 = PROD_W'(hist.x1) * PROD_W'(cfg.b1);
  assign p_b2 = PROD_W'(hist.x2) * PROD_W'(cfg.b2);
  assign p_a1 = PROD_W'(hist.y1) * PROD_W'(cfg.a1);
  assign p_a2 = PROD_W'(hist.y2) * PROD_W'(cfg.a2);

  // Exact sum plus half an LSB
  assign acc = ACC_W'(p_b0) + ACC_W'(p_b1) + ACC_W'(p_b2)
             - ACC_W'(p_a1) - ACC_W'(p_a2) + RND;

  // Floor shift, then clamp when the top bits are not a sign extension
  assign sh  = acc[ACC_W-1:COEF_FRAC];
  assign ovf = !((&sh[SH_W-1:SAMPLE_W-1]) || !(|sh[SH_W-1:SAMPLE_W-1]));

  always_comb begin
    if (ovf) begin
      y = sh[SH_W-1] ? {1'b1, {(SAMPLE_W-1){1'b0}}} : {1'b0, {(SAMPLE_W-1){1'b1}}};
    end else begin
      y = sh[SAMPLE_W-1:0];
    end
  end

endmodule

// ===== verif/multichannel_biquad_filter_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// multichannel_biquad_filter_checker
// Passive scoreboard for the biquad filter. It follows register writes,
// predicts one output beat per accepted input beat, and compares each output
// beat field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module multichannel_biquad_filter_checker (
  input  logic                           clk,
  input  logic                           rst,
  mbq_in_if                              in_ch,
  mbq_out_if                             out_ch,
  input  logic                           cfg_we,
  input  logic [mbq_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mbq_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                             fail_count,
  output int                             pending_count,
  output int                             checked_count
);
  import mbq_pkg::*;

  localparam longint SAMPLE_HI      = (longint'(1) <<< (SAMPLE_W - 1)) - 1;
  localparam longint SAMPLE_LO      = -SAMPLE_HI - 1;
  localparam coef_t  COEF_AT_RESET  = coef_t'(64'd1 << COEF_FRAC);
  localparam count_t COUNT_AT_RESET = count_t'(2);
  localparam int     MAX_REPORTS    = 100;

  typedef struct packed {
    sample_t sample_out;
    chan_t   channel_index;
  } filtered_beat_t;

  cfg_t           shadow_cfg;
  hist_t          chan_hist [MAX_CHANNELS];
  chan_t          next_chan;
  filtered_beat_t predicted_beats [$];

  // One direct-form-I step: Q1.23 x Q2.30 products, round half up, saturate
  function automatic sample_t biquad_sample(input cfg_t c, input sample_t x, input hist_t h);
    longint acc;
    acc = longint'($signed(c.b0)) * longint'($signed(x))
        + longint'($signed(c.b1)) * longint'($signed(h.x1))
        + longint'($signed(c.b2)) * longint'($signed(h.x2))
        - longint'($signed(c.a1)) * longint'($signed(h.y1))
        - longint'($signed(c.a2)) * longint'($signed(h.y2));
    acc = acc + (longint'(1) <<< (COEF_FRAC - 1));
    acc = acc >>> COEF_FRAC;
    if (acc > SAMPLE_HI) return sample_t'(SAMPLE_HI);
    if (acc < SAMPLE_LO) return sample_t'(SAMPLE_LO);
    return sample_t'(acc);
  endfunction

  function automatic void report_fail(input string what, input longint want, input longint got);
    fail_count++;
    if (fail_count <= MAX_REPORTS)
      $error("%s mismatch: expected %0d, got %0d", what, want, got);
  endfunction

  always @(posedge clk) begin : track
    filtered_beat_t want;
    int             eff_count;
    chan_t          ch;
    sample_t        x;
    sample_t        y;
    if (rst) begin
      shadow_cfg    = '0;
      shadow_cfg.b0 = COEF_AT_RESET;
      shadow_cfg.count = COUNT_AT_RESET;
      for (int i = 0; i < MAX_CHANNELS; i++) chan_hist[i] = '0;
      next_chan     = '0;
      predicted_beats.delete();
      fail_count    = 0;
      checked_count = 0;
    end else begin
      // output beat against the oldest prediction
      if (out_ch.valid && out_ch.ready) begin
        if (predicted_beats.size() == 0) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $error("output beat with nothing predicted: sample_out %0d, channel_index %0d",
                   $signed(out_ch.sample_out), out_ch.channel_index);
        end else begin
          want = predicted_beats.pop_front();
          if (out_ch.sample_out !== want.sample_out)
            report_fail("sample_out", $signed(want.sample_out), $signed(out_ch.sample_out));
          if (out_ch.channel_index !== want.channel_index)
            report_fail("channel_index", want.channel_index, out_ch.channel_index);
          checked_count++;
        end
      end

      // register writes; unknown indexes are dropped
      if (cfg_we) begin
        case (cfg_index)
          REG_COEF_B0:       shadow_cfg.b0 = coef_t'(cfg_data);
          REG_COEF_B1:       shadow_cfg.b1 = coef_t'(cfg_data);
          REG_COEF_B2:       shadow_cfg.b2 = coef_t'(cfg_data);
          REG_COEF_A1:       shadow_cfg.a1 = coef_t'(cfg_data);
          REG_COEF_A2:       shadow_cfg.a2 = coef_t'(cfg_data);
          REG_FILTER_ENABLE: shadow_cfg.enable = cfg_data[0];
          REG_CHANNEL_COUNT: shadow_cfg.count = cfg_data[CNT_W-1:0];
          default: ;
        endcase
      end

      // input beat: predict and advance the channel counter
      if (in_ch.valid && in_ch.ready) begin
        ch = next_chan;
        x  = in_ch.sample_in;
        eff_count = int'(shadow_cfg.count);
        if (eff_count == 0) eff_count = 1;
        if (eff_count > MAX_CHANNELS) eff_count = MAX_CHANNELS;
        if (shadow_cfg.enable) begin
          y = biquad_sample(shadow_cfg, x, chan_hist[ch]);
          chan_hist[ch].y2 = chan_hist[ch].y1;
          chan_hist[ch].y1 = y;
          chan_hist[ch].x2 = chan_hist[ch].x1;
          chan_hist[ch].x1 = x;
        end else begin
          y = x;
        end
        want.sample_out    = y;
        want.channel_index = ch;
        predicted_beats.push_back(want);
        // a counter left above a lowered count still serves this beat, then wraps
        if (int'(ch) + 1 >= eff_count) next_chan = '0;
        else next_chan = ch + 1'b1;
      end
    end
    pending_count = predicted_beats.size();
  end

endmodule

// ===== verif/multichannel_biquad_filter_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// multichannel_biquad_filter_tb
// Drives interleaved samples and register writes into the biquad filter with
// random gaps and output stalls, including one long output stall. A directed
// run hits passthrough, unity gain, saturation, channel count corner values
// and rounding; random phases then sweep coefficient sets and channel counts.
// ----------------------------------------------------------------------------
module multichannel_biquad_filter_tb;
  import mbq_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  localparam int RANDOM_ITEMS = 950;
  localparam int HOLD_AFTER   = 400;
  localparam int LONG_HOLD    = 300;
  localparam int DRAIN_CYCLES = 8;
  localparam int CYCLE_LIMIT  = 400_000;

  localparam sample_t SAMPLE_MAX   = {1'b0, {(SAMPLE_W-1){1'b1}}};
  localparam sample_t SAMPLE_MIN   = {1'b1, {(SAMPLE_W-1){1'b0}}};
  localparam coef_t   COEF_MAX     = {1'b0, {(COEF_W-1){1'b1}}};
  localparam coef_t   COEF_MIN     = {1'b1, {(COEF_W-1){1'b0}}};
  localparam coef_t   COEF_ONE     = coef_t'(64'd1 << COEF_FRAC);
  localparam coef_t   COEF_HALF    = coef_t'(64'd1 << (COEF_FRAC - 1));
  localparam coef_t   COEF_QUARTER = coef_t'(64'd1 << (COEF_FRAC - 2));

  // spans for coefficient sets that mostly stay out of saturation
  localparam int unsigned B_SPAN  = 32'd1 << (COEF_FRAC - 1);
  localparam int unsigned A1_SPAN = 32'd3 << (COEF_FRAC - 2);
  localparam int unsigned A2_SPAN = 32'd200_000_000;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int fail_count;
  int pending_count;
  int checked_count;
  int samples_sent;
  int settings_applied;
  int in_calm;
  int cycle_count;

  mbq_in_if  in_ch ();
  mbq_out_if out_ch ();

  multichannel_biquad_filter u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  multichannel_biquad_filter_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .in_ch         (in_ch),
    .out_ch        (out_ch),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .fail_count    (fail_count),
    .pending_count (pending_count),
    .checked_count (checked_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Gap length: mostly none or short, now and then long, with calm stretches
  function automatic int next_gap(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 149) == 0) begin
      calm = $urandom_range(20, 80);
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 97) return $urandom_range(1, 4);
    return $urandom_range(10, 40);
  endfunction

  function automatic sample_t rand_sample();
    case ($urandom_range(0, 9))
      0: return $urandom_range(0, 1) ? SAMPLE_MAX : SAMPLE_MIN;
      1: return sample_t'(int'($urandom_range(0, 2000)) - 1000);
      default: return sample_t'($urandom);
    endcase
  endfunction

  function automatic coef_t rand_coef(input int unsigned span);
    return coef_t'(longint'($urandom_range(0, 2 * span)) - longint'(span));
  endfunction

  function automatic coef_t extreme_coef();
    case ($urandom_range(0, 2))
      0: return COEF_MAX;
      1: return COEF_MIN;
      default: return '0;
    endcase
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Full register set; spare bits of the narrow registers carry noise
  task automatic apply_settings(input coef_t b0, input coef_t b1, input coef_t b2,
                                input coef_t a1, input coef_t a2,
                                input logic en, input count_t cnt);
    logic [CFG_DATA_W-1:0] noise;
    noise = $urandom;
    write_reg(REG_COEF_B0, b0);
    write_reg(REG_COEF_B1, b1);
    write_reg(REG_COEF_B2, b2);
    write_reg(REG_COEF_A1, a1);
    write_reg(REG_COEF_A2, a2);
    write_reg(REG_FILTER_ENABLE, {noise[CFG_DATA_W-1:1], en});
    write_reg(REG_CHANNEL_COUNT, {noise[CFG_DATA_W-1:CNT_W], cnt});
    write_reg(REG_UNUSED, $urandom);
    settings_applied++;
  endtask

  task automatic send_sample(input sample_t x);
    int gap;
    gap = next_gap(in_calm);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.sample_in <= x;
    do @(posedge clk); while (!in_ch.ready);
    samples_sent++;
  endtask

  // Stop offering beats and let every predicted beat come out
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_count != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Output side: random stalls, plus one long hold-off while input keeps coming
  initial begin : out_ready_drive
    int stall;
    int calm;
    bit held;
    calm = 0;
    held = 1'b0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      stall = next_gap(calm);
      if (!held && samples_sent >= HOLD_AFTER) begin
        held  = 1'b1;
        stall = LONG_HOLD;
      end
      out_ch.ready <= (stall == 0);
      if (stall > 1) repeat (stall - 1) @(posedge clk);
    end
  end

  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Timed out after %0d cycles with %0d beats outstanding",
             cycle_count, pending_count);
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin : stimulus
    coef_t  b0, b1, b2, a1, a2;
    logic   en;
    count_t cnt;
    int     coef_kind;
    int     count_kind;
    int     n;
    int     directed_sent;
    rst              = 1'b1;
    in_ch.valid      = 1'b0;
    in_ch.sample_in  = '0;
    cfg_we           = 1'b0;
    cfg_index        = '0;
    cfg_data         = '0;
    samples_sent     = 0;
    settings_applied = 0;
    in_calm          = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // reset state: passthrough over two channels
    send_sample('0);
    send_sample(sample_t'(1));
    send_sample(sample_t'(-1));
    send_sample(SAMPLE_MAX);
    send_sample(SAMPLE_MIN);
    wait_idle();

    // unity gain, one channel; counter sits at the new count once
    apply_settings(COEF_ONE, '0, '0, '0, '0, 1'b1, count_t'(1));
    send_sample(SAMPLE_MAX);
    send_sample(SAMPLE_MIN);
    send_sample(sample_t'(12345));
    wait_idle();

    // extreme coefficients, zero count: saturation both ways
    apply_settings(COEF_MAX, COEF_MAX, COEF_MAX, COEF_MIN, COEF_MIN, 1'b1, count_t'(0));
    send_sample(SAMPLE_MAX);
    send_sample(SAMPLE_MAX);
    send_sample(SAMPLE_MIN);
    send_sample(SAMPLE_MIN);
    send_sample(SAMPLE_MIN);
    wait_idle();

    // count above the channel limit; half-LSB rounding on +1 and -1
    apply_settings(COEF_HALF, COEF_QUARTER, -COEF_QUARTER, -COEF_HALF, COEF_QUARTER,
                   1'b1, count_t'(15));
    send_sample(sample_t'(1));
    send_sample(sample_t'(-1));
    repeat (6) send_sample(rand_sample());
    wait_idle();

    // passthrough again: history must survive it
    apply_settings(COEF_HALF, COEF_QUARTER, -COEF_QUARTER, -COEF_HALF, COEF_QUARTER,
                   1'b0, count_t'(3));
    repeat (2) send_sample(rand_sample());
    wait_idle();
    directed_sent = samples_sent;

    // random phases, each under a fresh setting
    while (samples_sent < directed_sent + RANDOM_ITEMS) begin
      coef_kind = $urandom_range(0, 9);
      if (coef_kind == 0) begin
        b0 = coef_t'($urandom); b1 = coef_t'($urandom); b2 = coef_t'($urandom);
        a1 = coef_t'($urandom); a2 = coef_t'($urandom);
      end else if (coef_kind == 1) begin
        b0 = extreme_coef(); b1 = extreme_coef(); b2 = extreme_coef();
        a1 = extreme_coef(); a2 = extreme_coef();
      end else begin
        b0 = rand_coef(B_SPAN); b1 = rand_coef(B_SPAN); b2 = rand_coef(B_SPAN);
        a1 = rand_coef(A1_SPAN); a2 = rand_coef(A2_SPAN);
      end
      en = ($urandom_range(0, 7) != 0);
      count_kind = $urandom_range(0, 9);
      if (count_kind == 0) cnt = '0;
      else if (count_kind == 1) cnt = count_t'($urandom_range(MAX_CHANNELS + 1, 15));
      else cnt = count_t'($urandom_range(1, MAX_CHANNELS));
      apply_settings(b0, b1, b2, a1, a2, en, cnt);

      n = $urandom_range(40, 160);
      if (n > directed_sent + RANDOM_ITEMS - samples_sent)
        n = directed_sent + RANDOM_ITEMS - samples_sent;
      repeat (n) send_sample(rand_sample());
      wait_idle();
    end

    $display("Covered %0d samples (%0d directed) under %0d filter settings;",
             samples_sent, directed_sent, settings_applied);
    $display("%0d output beats compared against the predicted stream.", checked_count);
    if (fail_count == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule
